@@ rtl/rgb_to_hsv_hsl_assert.svh @@
// Assertion macros for the HSV/HSL converter.
`ifndef RGB_TO_HSV_HSL_ASSERT_SVH
`define RGB_TO_HSV_HSL_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define RHH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhh assertion failed");

// Next-cycle implication.
`define RHH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhh assertion failed");

`endif

@@ rtl/rhh_pkg.sv @@
package rhh_pkg;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int OUT_FRAC_W        = 16;
  localparam int CH_W              = 8;

  typedef enum logic [1:0] {
    HUE_ZERO  = 2'd0,
    HUE_GREEN = 2'd1,
    HUE_BLUE  = 2'd2,
    HUE_RED   = 2'd3
  } hue_sel_t;
endpackage

@@ rtl/rhh_if.sv @@
interface rhh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhh_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [15:0] sat_hsv;
  logic [7:0]  value_level;
  logic [15:0] sat_hsl;
  logic [8:0]  lightness_twice;
  modport source (output valid, hue, sat_hsv, value_level, sat_hsl, lightness_twice,
                  input ready);
  modport sink   (input valid, hue, sat_hsv, value_level, sat_hsl, lightness_twice,
                  output ready);
endinterface

@@ rtl/rhh_div_cell.sv @@
// One restoring-division step for three independent quotients.
// Partial remainder stays below the divisor; one quotient bit per cell.
module rhh_div_cell #(
  parameter int NW = 12,   // remainder/divisor width
  parameter int QW = 17,   // quotient width
  parameter int SW = 17    // side data width
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] rem_i [3],
  input  logic [NW-1:0] den_i [3],
  input  logic [QW-1:0] quo_i [3],
  input  logic [SW-1:0] side_i,
  output logic [NW-1:0] rem_o [3],
  output logic [NW-1:0] den_o [3],
  output logic [QW-1:0] quo_o [3],
  output logic [SW-1:0] side_o
);
  logic [NW:0]   trial [3];
  logic [NW-1:0] rem_nxt [3];
  logic [QW-1:0] quo_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem_i[k], 1'b0};
      if (trial[k] >= {1'b0, den_i[k]}) begin
        rem_nxt[k] = NW'(trial[k] - {1'b0, den_i[k]});
        quo_nxt[k] = {quo_i[k][QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[k][NW-1:0];
        quo_nxt[k] = {quo_i[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      den_o  <= den_i;
      quo_o  <= quo_nxt;
      side_o <= side_i;
    end
  end
endmodule

@@ rtl/rgb_to_hsv_hsl.sv @@
// RGB to HSV/HSL converter. Accepts one pixel per clock unless stalled and returns one
// result per pixel through a registered max/min/numerator setup stage, then a row of
// FRACTION_BITS+1 division cells, each producing one quotient bit of hue, HSV
// saturation and HSL saturation. The whole row advances whenever the output register is
// empty or being taken, so throughput is one pixel per clock without stalls.
`include "rgb_to_hsv_hsl_assert.svh"
module rgb_to_hsv_hsl #(
  parameter int FRACTION_BITS = rhh_pkg::FRACTION_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  rhh_in_if.sink    in_if,
  rhh_out_if.source out_if
);
  localparam int NW = 12;             // holds twice 6*c, up to 3060
  localparam int QW = FRACTION_BITS + 1;
  localparam int NS = FRACTION_BITS + 1;
  localparam int FW = rhh_pkg::OUT_FRAC_W;
  localparam int SW = 17;             // {max, max+min}

  logic en;
  logic [NS:0] vld_r;
  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en && rst_n;

  // setup stage
  logic [7:0] r, g, b, mx, mn, c;
  logic [8:0] sum;
  rhh_pkg::hue_sel_t sel;
  logic [NW-1:0] hnum, hden, snum, sden, lnum, lden;
  logic hz, sz, lz;

  always_comb begin
    r = in_if.red; g = in_if.green; b = in_if.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    hden = NW'(c) * NW'(6);
    priority if (c == 8'd0) sel = rhh_pkg::HUE_ZERO;
    else if (g == mx) sel = rhh_pkg::HUE_GREEN;
    else if (b == mx) sel = rhh_pkg::HUE_BLUE;
    else sel = rhh_pkg::HUE_RED;
    unique case (sel)
      rhh_pkg::HUE_GREEN: hnum = NW'(b) + (NW'(c) << 1) - NW'(r);
      rhh_pkg::HUE_BLUE:  hnum = (NW'(c) << 2) + NW'(r) - NW'(g);
      rhh_pkg::HUE_RED:   hnum = (g >= b) ? NW'(g - b) : hden + NW'(g) - NW'(b);
      default:            hnum = '0;
    endcase
    hz = (sel == rhh_pkg::HUE_ZERO);
    if (hz) hden = NW'(1);
    snum = NW'(c);
    sz = (mx == 8'd0);
    sden = sz ? NW'(1) : NW'(mx);
    lnum = NW'(c);
    lz = (mx == 8'd0) || (mn == 8'hff);
    if (lz) lden = NW'(1);
    else if (sum <= 9'd255) lden = NW'(sum);
    else lden = NW'(10'd510 - {1'b0, sum});
  end

  // numerators never exceed denominators; divisors are stored doubled so the
  // first cell yields the integer bit and the rest yield the fraction bits
  logic [NW-1:0] rem0_r [3];
  logic [NW-1:0] den0_r [3];
  logic [SW-1:0] side0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r[0] <= hz ? '0 : hnum;
      rem0_r[1] <= sz ? '0 : snum;
      rem0_r[2] <= lz ? '0 : lnum;
      den0_r[0] <= hden << 1;
      den0_r[1] <= sden << 1;
      den0_r[2] <= lden << 1;
      side0_r   <= {mx, sum};
    end
  end

  logic [NW-1:0] rem_a [NS+1][3];
  logic [NW-1:0] den_a [NS+1][3];
  logic [QW-1:0] quo_a [NS+1][3];
  logic [SW-1:0] side_a [NS+1];

  assign rem_a[0]  = rem0_r;
  assign den_a[0]  = den0_r;
  assign quo_a[0]  = '{'0, '0, '0};
  assign side_a[0] = side0_r;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    rhh_div_cell #(.NW(NW), .QW(QW), .SW(SW)) u_cell (
      .clk(clk), .en(en),
      .rem_i(rem_a[i]), .den_i(den_a[i]), .quo_i(quo_a[i]), .side_i(side_a[i]),
      .rem_o(rem_a[i+1]), .den_o(den_a[i+1]), .quo_o(quo_a[i+1]), .side_o(side_a[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NS-1:0], in_if.valid && in_if.ready};
  end

  // quotient is num*2^FRACTION_BITS/den; top bit set means exactly 1.0
  logic [FW-1:0] q_sat [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (quo_a[NS][k][QW-1]) q_sat[k] = FW'((QW'(1) << FRACTION_BITS) - QW'(1));
      else q_sat[k] = FW'(quo_a[NS][k]);
    end
  end

  assign out_if.valid           = vld_r[NS];
  assign out_if.hue             = q_sat[0];
  assign out_if.sat_hsv         = q_sat[1];
  assign out_if.sat_hsl         = q_sat[2];
  assign out_if.value_level     = side_a[NS][16:9];
  assign out_if.lightness_twice = side_a[NS][8:0];

  `RHH_ASSERT_IMP(a_stall_hold, clk, rst_n, out_if.valid && !out_if.ready, !in_if.ready)
  `RHH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_if.valid && !out_if.ready,
                   out_if.valid && $stable(out_if.hue))
  `RHH_ASSERT_IMP(a_light, clk, rst_n, out_if.valid,
                  {1'b0, out_if.value_level} <= out_if.lightness_twice)
endmodule

@@ tb/rgb_to_hsv_hsl_test.sv @@
module rgb_to_hsv_hsl_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = rhh_pkg::FRACTION_BITS_DEF;
  localparam int LATENCY = FB + 2;
  localparam int WATCHDOG = 5000;

  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] sat_hsv;
    logic [7:0]  value_level;
    logic [15:0] sat_hsl;
    logic [8:0]  lightness_twice;
  } hsx_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bit         known;
    hsx_t       res;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  rhh_in_if in_ch();
  rhh_out_if out_ch();

  rgb_to_hsv_hsl u_dut (.clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source));

  always #1 clk = ~clk;

  hsx_t hsx_queue[$];
  int   errors = 0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   quiet_cycles = 0;

  function automatic logic [15:0] frac_ratio(int unsigned num, int unsigned den);
    longint unsigned q;
    q = (longint'(num) << FB) / den;
    if (q > (64'd1 << FB) - 1) q = (64'd1 << FB) - 1;
    return q[15:0];
  endfunction

  function automatic hsx_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsx_t o;
    int unsigned mx, mn, c, sum;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = mx - mn;
    sum = mx + mn;
    o = '0;
    if (c != 0) begin
      if (g == mx) o.hue = frac_ratio(b + 2 * c - r, 6 * c);
      else if (b == mx) o.hue = frac_ratio(4 * c + r - g, 6 * c);
      else if (g >= b) o.hue = frac_ratio(g - b, 6 * c);
      else o.hue = frac_ratio(6 * c + g - b, 6 * c);
    end
    if (mx != 0) o.sat_hsv = frac_ratio(c, mx);
    if (mx != 0 && mn != 255) begin
      if (sum <= 255) o.sat_hsl = frac_ratio(c, sum);
      else o.sat_hsl = frac_ratio(c, 510 - sum);
    end
    o.value_level = mx[7:0];
    o.lightness_twice = sum[8:0];
    return o;
  endfunction

  // Directed pixels; known results are typed where obvious.
  pixel_row_t pixel_table[] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0, 16'd0, 8'd0, 16'd0, 9'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{16'd0, 16'd0, 8'd255, 16'd0, 9'd510}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{16'd0, 16'hFFFF, 8'd255, 16'hFFFF, 9'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{16'd0, 16'd0, 8'd128, 16'd0, 9'd256}},
    '{8'd0,   8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd255, 8'd1,   8'd0,   1'b0, '0},
    '{8'd255, 8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd255, 8'd254, 8'd254, 1'b0, '0},
    '{8'd200, 8'd100, 8'd50,  1'b0, '0},
    '{8'd50,  8'd100, 8'd200, 1'b0, '0},
    '{8'd100, 8'd200, 8'd50,  1'b0, '0},
    '{8'd128, 8'd127, 8'd127, 1'b0, '0},
    '{8'd128, 8'd128, 8'd127, 1'b0, '0},
    '{8'd170, 8'd85,  8'd0,   1'b0, '0},
    '{8'd10,  8'd10,  8'd20,  1'b0, '0}
  };

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.red   <= r;
    in_ch.green <= g;
    in_ch.blue  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Predict on acceptance.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      hsx_queue.push_back(convert_pixel(in_ch.red, in_ch.green, in_ch.blue));
  end

  always @(posedge clk) begin
    hsx_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hsx_queue.size() == 0) begin
        $error("result with no pending request");
        errors++;
      end else begin
        want = hsx_queue.pop_front();
        if (out_ch.hue !== want.hue) begin
          $error("hue exp %0d got %0d", want.hue, out_ch.hue); errors++;
        end
        if (out_ch.sat_hsv !== want.sat_hsv) begin
          $error("sat_hsv exp %0d got %0d", want.sat_hsv, out_ch.sat_hsv); errors++;
        end
        if (out_ch.value_level !== want.value_level) begin
          $error("value_level exp %0d got %0d", want.value_level, out_ch.value_level);
          errors++;
        end
        if (out_ch.sat_hsl !== want.sat_hsl) begin
          $error("sat_hsl exp %0d got %0d", want.sat_hsl, out_ch.sat_hsl); errors++;
        end
        if (out_ch.lightness_twice !== want.lightness_twice) begin
          $error("lightness_twice exp %0d got %0d", want.lightness_twice,
                 out_ch.lightness_twice);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    hsx_t typed;
    in_ch.valid = 1'b0;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 38;
    snk_idle_pct = 60;
    foreach (pixel_table[i]) begin
      if (pixel_table[i].known) begin
        typed = convert_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b);
        if (typed !== pixel_table[i].res) begin
          $error("table row %0d exp %h got %h", i, pixel_table[i].res, typed);
          errors++;
        end
      end
      send_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b);
    end

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 60 : 0;
      snk_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 38 : 0;
      for (int n = 0; n < 530; n++) begin
        if (n == 265) begin
          in_ch.valid <= 1'b0;
          wait (hsx_queue.size() == 0);
          @(negedge clk);
        end
        // gray and near-gray pixels hit the chroma edge cases
        if ($urandom_range(9) == 0) begin
          typed.value_level = rand_channel();
          send_pixel(typed.value_level, 8'(typed.value_level + $urandom_range(1)),
                     typed.value_level);
        end else begin
          send_pixel(rand_channel(), rand_channel(), rand_channel());
        end
      end
    end

    in_ch.valid <= 1'b0;
    wait (hsx_queue.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rhh_pkg.sv
rtl/rhh_if.sv
rtl/rhh_div_cell.sv
rtl/rgb_to_hsv_hsl.sv
tb/rgb_to_hsv_hsl_test.sv
